### sv/hpc_pkg.sv
// Shared types and constants for the hysteresis pulse counter.
package hpc_pkg;

   localparam int CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CHANNEL_W  = 3;
   localparam int SAMPLE_W   = 15;
   localparam int VALUE_W    = 16;
   localparam int ACC_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int ACC_SPLIT  = 16;

   localparam logic [VALUE_W-1:0] HYST_BASE     = 16'd100;
   localparam int                 HYST_SCALE    = 5;
   localparam logic [VALUE_W-1:0] HYST_RESET    = HYST_BASE << HYST_SCALE;
   localparam logic [SHIFT_W-1:0] LONG_FORM_MIN = 4'd6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HYSTERESIS = 2'd0,
      CSR_SMOOTHING  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                 in_range;
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } item_type;

endpackage

### sv/hysteresis_pulse_counter_unit.sv
// Top level of the hysteresis pulse counter.
//
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_ready   req_channel, req_sample
//  rsp_      out        rsp_valid/rsp_ready   rsp_count, rsp_level_high, rsp_counted,
//                                             rsp_filtered
//  csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One sample per cycle sustained while rsp_ does not stall; each result passes a queue slot,
// then the output register. The per-channel filter and tracking update reads register arrays
// and writes them back as the sample is taken, so same-channel samples need no stall.
// Synchronous reset clears the queue, the output valid flag and all channel state at once.
// A stalled rsp_ fills the output register and the two-entry queue before req_ready drops.
module hysteresis_pulse_counter_unit
   import hpc_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHANNEL_W-1:0]  req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_level_high,
   output logic                  rsp_counted,
   output logic [VALUE_W-1:0]    rsp_filtered,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   hpc_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_channel (req_channel),
      .req_sample  (req_sample),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   hpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   hpc_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_item       (pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_count      (rsp_count),
      .rsp_level_high (rsp_level_high),
      .rsp_counted    (rsp_counted),
      .rsp_filtered   (rsp_filtered)
   );

endmodule

### sv/hpc_front.sv
// Front end: accepts samples, checks the channel number and pushes them into the queue.
module hpc_front
   import hpc_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHANNEL_W-1:0] req_channel,
   input  logic [SAMPLE_W-1:0]  req_sample,
   output logic                 push_valid,
   input  logic                 push_ready,
   output item_type             push_item
);

   localparam logic [CHANNEL_W:0] CHAN_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_item.in_range = ({1'b0, req_channel} < CHAN_LIMIT);
      push_item.channel  = req_channel;
      push_item.sample   = req_sample;
   end

endmodule

### sv/hpc_queue.sv
// Short queue between the front end and the channel update stage.
module hpc_queue
   import hpc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W:0]   FULL_COUNT = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

   item_type         entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != FULL_COUNT);
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### sv/hpc_back.sv
// Back end: control registers, per-channel filter, extreme tracking, level and counters.
module hpc_back
   import hpc_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  item_type              pop_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COUNT_W-1:0]    rsp_count,
   output logic                  rsp_level_high,
   output logic                  rsp_counted,
   output logic [VALUE_W-1:0]    rsp_filtered
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [VALUE_W-1:0] hyst_ff;
   logic [SHIFT_W-1:0] shift_ff;

   logic [ACC_W-1:0]   acc_ff   [CHANNELS];
   logic [VALUE_W-1:0] ext_ff   [CHANNELS];
   logic [COUNT_W-1:0] cnt_ff   [CHANNELS];
   logic [CHANNELS-1:0] level_ff;

   logic               rsp_valid_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_level_ff;
   logic               rsp_counted_ff;
   logic [VALUE_W-1:0] rsp_filtered_ff;

   logic [IDX_W-1:0]   idx;
   logic [ACC_W-1:0]   acc_rd;
   logic [VALUE_W-1:0] ext_rd;
   logic [COUNT_W-1:0] cnt_rd;
   logic               lvl_rd;
   logic [VALUE_W-1:0] x16;
   logic [VALUE_W-1:0] prev16;
   logic [VALUE_W-1:0] short16;
   logic [4:0]         left_amt;
   logic [ACC_W-1:0]   long32;
   logic [VALUE_W-1:0] filt;
   logic [ACC_W-1:0]   acc_in;
   logic [VALUE_W-1:0] ext_in;
   logic               lvl_in;
   logic               counted;
   logic [COUNT_W-1:0] cnt_inc;
   logic [VALUE_W:0]   ext_hi;
   logic [VALUE_W:0]   filt_hi;
   logic               take;
   logic               write_state;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign write_state = take && pop_item.in_range;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_level_high = rsp_level_ff;
   assign rsp_counted    = rsp_counted_ff;
   assign rsp_filtered   = rsp_filtered_ff;

   always_comb begin
      idx    = pop_item.channel[IDX_W-1:0];
      acc_rd = acc_ff[idx];
      ext_rd = ext_ff[idx];
      cnt_rd = cnt_ff[idx];
      lvl_rd = level_ff[idx];
      x16    = {1'b0, pop_item.sample};

      prev16   = acc_rd[VALUE_W-1:0];
      short16  = (x16 >> shift_ff) + prev16 - (prev16 >> shift_ff);
      left_amt = 5'(ACC_SPLIT) - {1'b0, shift_ff};
      long32   = (ACC_W'(pop_item.sample) << left_amt) + acc_rd - (acc_rd >> shift_ff);

      if (shift_ff == '0) begin
         filt   = x16;
         acc_in = acc_rd;
      end else if (shift_ff < LONG_FORM_MIN) begin
         filt   = short16;
         acc_in = {{(ACC_W - VALUE_W){1'b0}}, short16};
      end else begin
         filt   = long32[ACC_W-1:ACC_SPLIT];
         acc_in = long32;
      end

      ext_hi  = {1'b0, ext_rd} + {1'b0, hyst_ff};
      filt_hi = {1'b0, filt} + {1'b0, hyst_ff};
      cnt_inc = cnt_rd + 1'b1;

      ext_in  = ext_rd;
      lvl_in  = lvl_rd;
      counted = 1'b0;
      if (!lvl_rd) begin
         if (filt < ext_rd) begin
            ext_in = filt;
         end else if ({1'b0, filt} > ext_hi) begin
            lvl_in  = 1'b1;
            counted = 1'b1;
            ext_in  = filt;
         end
      end else begin
         if (filt > ext_rd) begin
            ext_in = filt;
         end else if (filt_hi < {1'b0, ext_rd}) begin
            lvl_in = 1'b0;
            ext_in = filt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff  <= HYST_RESET;
         shift_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HYSTERESIS: hyst_ff  <= csr_wdata;
            CSR_SMOOTHING:  shift_ff <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            acc_ff[i] <= '0;
            ext_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         level_ff <= '0;
      end else if (write_state) begin
         acc_ff[idx]   <= acc_in;
         ext_ff[idx]   <= ext_in;
         level_ff[idx] <= lvl_in;
         if (counted) begin
            cnt_ff[idx] <= cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         if (pop_item.in_range) begin
            rsp_count_ff    <= counted ? cnt_inc : cnt_rd;
            rsp_level_ff    <= lvl_in;
            rsp_counted_ff  <= counted;
            rsp_filtered_ff <= filt;
         end else begin
            rsp_count_ff    <= '0;
            rsp_level_ff    <= 1'b0;
            rsp_counted_ff  <= 1'b0;
            rsp_filtered_ff <= x16;
         end
      end
   end

endmodule

### tb/sv/tb.sv
// Testbench for the hysteresis pulse counter: queued stimulus, clocked driver and monitor.
`timescale 1ns / 1ps

module tb;
   import hpc_pkg::*;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  sample;
   } sample_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               level_high;
      logic               counted;
      logic [VALUE_W-1:0] filtered;
   } count_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CHANNEL_W-1:0]  req_channel = '0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COUNT_W-1:0]    rsp_count;
   logic                  rsp_level_high;
   logic                  rsp_counted;
   logic [VALUE_W-1:0]    rsp_filtered;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_HYSTERESIS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   hysteresis_pulse_counter_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_channel    (req_channel),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_count      (rsp_count),
      .rsp_level_high (rsp_level_high),
      .rsp_counted    (rsp_counted),
      .rsp_filtered   (rsp_filtered),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model state and configuration
   logic [ACC_W-1:0]   decay_acc_m [8];
   logic [VALUE_W-1:0] extreme_m [8];
   logic [7:0]         level_m;
   logic [COUNT_W-1:0] pulse_m [8];
   logic [VALUE_W-1:0] hyst_cfg;
   logic [SHIFT_W-1:0] shift_cfg;

   sample_item_type  sample_queue[$];
   count_result_type awaited_results[$];
   sample_item_type  next_item;
   count_result_type got, want;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int samples_queued = 0;
   int results_seen   = 0;
   int mismatches     = 0;

   function automatic count_result_type track_sample(logic [CHANNEL_W-1:0] ch,
                                                     logic [SAMPLE_W-1:0] x);
      count_result_type r;
      logic [VALUE_W-1:0] f, ext, prev16, nxt16;
      logic [ACC_W-1:0]   x32, prev32, nxt32;
      logic [16:0]        f17, ext17, hy17;
      r = '0;
      x32 = ACC_W'(x);
      if (shift_cfg == 0) begin
         f = VALUE_W'(x);
      end else if (shift_cfg < LONG_FORM_MIN) begin
         prev16 = decay_acc_m[ch][VALUE_W-1:0];
         nxt16 = VALUE_W'(x32 >> shift_cfg) + prev16 - (prev16 >> shift_cfg);
         decay_acc_m[ch] = ACC_W'(nxt16);
         f = nxt16;
      end else begin
         prev32 = decay_acc_m[ch];
         nxt32 = (x32 << (ACC_SPLIT - int'(shift_cfg))) + prev32 - (prev32 >> shift_cfg);
         decay_acc_m[ch] = nxt32;
         f = nxt32[ACC_W-1:ACC_SPLIT];
      end
      ext = extreme_m[ch];
      f17 = {1'b0, f};
      ext17 = {1'b0, ext};
      hy17 = {1'b0, hyst_cfg};
      if (!level_m[ch]) begin
         if (f < ext) begin
            extreme_m[ch] = f;
         end else if (f17 > ext17 + hy17) begin
            level_m[ch] = 1'b1;
            pulse_m[ch] = pulse_m[ch] + 1;
            r.counted = 1'b1;
            extreme_m[ch] = f;
         end
      end else begin
         if (f > ext) begin
            extreme_m[ch] = f;
         end else if (f17 + hy17 < ext17) begin
            level_m[ch] = 1'b0;
            extreme_m[ch] = f;
         end
      end
      r.count = pulse_m[ch];
      r.level_high = level_m[ch];
      r.filtered = f;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            awaited_results.push_back(track_sample(req_channel, req_sample));
         if (!req_valid || req_ready) begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               next_item = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_channel <= next_item.channel;
               req_sample <= next_item.sample;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got = '{rsp_count, rsp_level_high, rsp_counted, rsp_filtered};
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: count %0d level %0d counted %0d filtered %0d",
                           got.count, got.level_high, got.counted, got.filtered);
            end else begin
               want = awaited_results.pop_front();
               if (got.count !== want.count || got.level_high !== want.level_high ||
                   got.counted !== want.counted || got.filtered !== want.filtered) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                              want.count, want.level_high, want.counted, want.filtered,
                              got.count, got.level_high, got.counted, got.filtered);
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_sample(int ch, int x);
      sample_item_type it;
      it.channel = CHANNEL_W'(ch);
      it.sample = SAMPLE_W'(x);
      sample_queue.push_back(it);
      samples_queued++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_HYSTERESIS)
         hyst_cfg = val;
      else if (idx == CSR_SMOOTHING)
         shift_cfg = val[SHIFT_W-1:0];
   endtask

   task automatic wait_drained();
      while (results_seen < samples_queued)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // square-ish waveforms per channel with jitter, mixed with raw noise
   task automatic queue_random(int n, int max_hold);
      int made, ch, lo, hi, hold, reps, v;
      made = 0;
      while (made < n) begin
         if ($urandom_range(0, 9) < 7) begin
            ch = $urandom_range(0, 7);
            lo = $urandom_range(0, 16000);
            hi = lo + $urandom_range(0, 32767 - lo);
            hold = $urandom_range(1, max_hold);
            reps = $urandom_range(1, 4);
            for (int r = 0; r < reps; r++) begin
               for (int h = 0; h < 2 * hold && made < n; h++) begin
                  v = ((h < hold) ? lo : hi) + $urandom_range(0, 300);
                  if (v > 32767)
                     v = 32767;
                  push_sample(ch, v);
                  made++;
               end
            end
         end else begin
            case ($urandom_range(0, 3))
               0: v = 0;
               1: v = 32767;
               default: v = $urandom_range(0, 32767);
            endcase
            push_sample($urandom_range(0, 7), v);
            made++;
         end
      end
   endtask

   task automatic run_phase(logic [15:0] hyst, logic [3:0] shift, int send_pct,
                            int recv_pct, int n, int max_hold);
      wait_drained();
      write_csr(CSR_HYSTERESIS, hyst);
      write_csr(CSR_SMOOTHING, CSR_DATA_W'(shift));
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_random(n, max_hold);
   endtask

   initial begin
      for (int i = 0; i < 8; i++) begin
         decay_acc_m[i] = '0;
         extreme_m[i] = '0;
         pulse_m[i] = '0;
      end
      level_m = '0;
      hyst_cfg = HYST_RESET;
      shift_cfg = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: full swings, threshold edges, all channels
      push_sample(0, 0);
      push_sample(0, 32767);
      push_sample(0, 32767);
      push_sample(0, 0);
      push_sample(0, 32767);
      push_sample(1, 3200);
      push_sample(1, 3201);
      push_sample(1, 1);
      push_sample(1, 0);
      for (int c = 2; c < 8; c++)
         push_sample(c, 32767);
      push_sample(3, 15'h5555);
      push_sample(5, 15'h2AAA);
      push_sample(7, 0);

      run_phase(16'd3200, 4'd0, 0, 0, 150, 4);
      run_phase(16'd0, 4'd0, 54, 0, 150, 4);
      run_phase(16'hFFFF, 4'd3, 0, 54, 150, 8);
      run_phase(16'($urandom_range(0, 2000)), 4'd9, 17, 17, 150, 16);
      run_phase(16'd500, 4'd2, 0, 0, 150, 8);
      run_phase(16'd0, 4'd15, 54, 0, 150, 16);
      run_phase(16'd1000, 4'd1, 0, 54, 150, 6);
      run_phase(16'd800, 4'd6, 17, 17, 150, 12);
      run_phase(16'($urandom_range(0, 4000)), 4'd5, 0, 0, 150, 8);
      run_phase(16'($urandom_range(0, 65535)), 4'd0, 17, 17, 60, 4);

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && awaited_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
sv/hpc_pkg.sv
sv/hpc_front.sv
sv/hpc_queue.sv
sv/hpc_back.sv
sv/hysteresis_pulse_counter_unit.sv
tb/sv/tb.sv
